FILE: src/tga_rle_pixel_decoder_assert.svh
// Assertion macros for the TGA RLE decoder checker.
// Both sample on clk and are disabled while arst_n is low.
`ifndef TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_ASSERT_SVH

// same-cycle implication
`define TRPD_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("trpd assertion failed");

// next-cycle implication
`define TRPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("trpd assertion failed");

`endif

FILE: src/trpd_pkg.sv
package trpd_pkg;

	localparam logic [24:0] MAX_IMAGE_PIXELS = 25'd16777216;
	localparam logic [7:0]  RUN_FLAG         = 8'd128;
	localparam logic [7:0]  RUN_BIAS         = 8'd127;
	localparam logic [2:0]  MAX_PIXEL_BYTES  = 3'd4;

	localparam logic CFG_PIXEL_BYTES  = 1'b0;
	localparam logic CFG_IMAGE_PIXELS = 1'b1;

	typedef struct packed {
		logic [2:0]  pixel_bytes;
		logic [24:0] image_pixels;
	} cfg_t;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       restart;
	} item_t;

	typedef struct packed {
		logic [31:0] pixel_value;
		logic [7:0]  repeat_count;
		logic [23:0] first_index;
		logic        image_done;
		logic        overflow_error;
	} result_t;

endpackage

FILE: src/trpd_cfg.sv
module trpd_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [24:0]   cfg_data,
	output trpd_pkg::cfg_t cfg
);
	import trpd_pkg::*;

	logic [2:0]  pixel_bytes_q;
	logic [24:0] image_pixels_q;
	logic [2:0]  bytes_eff;
	logic [24:0] pixels_eff;

	// registers hold the clamped values
	always_comb begin
		if (cfg_data[2:0] == 3'd0) begin
			bytes_eff = 3'd1;
		end else if (cfg_data[2:0] > MAX_PIXEL_BYTES) begin
			bytes_eff = MAX_PIXEL_BYTES;
		end else begin
			bytes_eff = cfg_data[2:0];
		end
		if (cfg_data == 25'd0) begin
			pixels_eff = 25'd1;
		end else if (cfg_data > MAX_IMAGE_PIXELS) begin
			pixels_eff = MAX_IMAGE_PIXELS;
		end else begin
			pixels_eff = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bytes_q  <= 3'd3;
			image_pixels_q <= 25'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PIXEL_BYTES:  pixel_bytes_q  <= bytes_eff;
				CFG_IMAGE_PIXELS: image_pixels_q <= pixels_eff;
			endcase
		end
	end

	assign cfg_ready        = 1'b1;
	assign cfg.pixel_bytes  = pixel_bytes_q;
	assign cfg.image_pixels = image_pixels_q;

endmodule

FILE: src/trpd_in_stage.sv
module trpd_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  trpd_pkg::item_t in_item,
	output logic            item_valid,
	output trpd_pkg::item_t item,
	input  logic            advance
);
	import trpd_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

FILE: src/trpd_decode.sv
module trpd_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  trpd_pkg::cfg_t    cfg,
	input  logic              item_valid,
	input  trpd_pkg::item_t   item,
	output logic              advance,
	output logic              out_valid,
	input  logic              out_ready,
	output trpd_pkg::result_t out_result
);
	import trpd_pkg::*;

	logic        expect_header_q;
	logic        packet_is_run_q;
	logic [7:0]  packet_pixels_left_q;
	logic [1:0]  byte_in_pixel_q;
	logic [31:0] pixel_gather_q;
	logic [24:0] pixels_decoded_q;
	logic        error_stuck_q;

	logic        out_valid_q;
	result_t     result_q;

	logic        hdr_run;
	logic [7:0]  hdr_count;
	logic [24:0] remaining;
	logic        hdr_overflow;
	logic [31:0] gather_next;
	logic        pixel_done;
	logic [7:0]  repeat_n;
	logic [24:0] decoded_next;
	logic [7:0]  left_next;
	logic        image_done;
	logic        res_valid;
	result_t     res;

	assign advance = item_valid && (!out_valid_q || out_ready);

	always_comb begin
		hdr_run      = item.stream_byte >= RUN_FLAG;
		hdr_count    = hdr_run ? item.stream_byte - RUN_BIAS : item.stream_byte + 8'd1;
		remaining    = (pixels_decoded_q < cfg.image_pixels) ?
			cfg.image_pixels - pixels_decoded_q : 25'd0;
		hdr_overflow = {17'd0, hdr_count} > remaining;

		gather_next  = pixel_gather_q |
			({24'd0, item.stream_byte} << {byte_in_pixel_q, 3'b000});
		pixel_done   = ({1'b0, byte_in_pixel_q} + 3'd1) >= cfg.pixel_bytes;

		if (packet_is_run_q && packet_pixels_left_q != 8'd0) begin
			repeat_n = packet_pixels_left_q;
		end else begin
			repeat_n = 8'd1;
		end
		decoded_next = pixels_decoded_q + {17'd0, repeat_n};
		left_next    = (packet_pixels_left_q >= repeat_n) ?
			packet_pixels_left_q - repeat_n : 8'd0;
		image_done   = decoded_next >= cfg.image_pixels;

		res_valid = 1'b0;
		res       = '0;
		if (!item.restart && !error_stuck_q) begin
			if (expect_header_q) begin
				if (hdr_overflow) begin
					res_valid          = 1'b1;
					res.first_index    = pixels_decoded_q[23:0];
					res.overflow_error = 1'b1;
				end
			end else if (pixel_done) begin
				res_valid        = 1'b1;
				res.pixel_value  = gather_next;
				res.repeat_count = repeat_n;
				res.first_index  = pixels_decoded_q[23:0];
				res.image_done   = image_done;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_header_q      <= 1'b1;
			packet_is_run_q      <= 1'b0;
			packet_pixels_left_q <= 8'd0;
			byte_in_pixel_q      <= 2'd0;
			pixel_gather_q       <= 32'd0;
			pixels_decoded_q     <= 25'd0;
			error_stuck_q        <= 1'b0;
		end else if (advance) begin
			if (item.restart) begin
				expect_header_q      <= 1'b1;
				packet_is_run_q      <= 1'b0;
				packet_pixels_left_q <= 8'd0;
				byte_in_pixel_q      <= 2'd0;
				pixel_gather_q       <= 32'd0;
				pixels_decoded_q     <= 25'd0;
				error_stuck_q        <= 1'b0;
			end else if (!error_stuck_q) begin
				if (expect_header_q) begin
					if (hdr_overflow) begin
						error_stuck_q <= 1'b1;
					end else begin
						packet_is_run_q      <= hdr_run;
						packet_pixels_left_q <= hdr_count;
						byte_in_pixel_q      <= 2'd0;
						pixel_gather_q       <= 32'd0;
						expect_header_q      <= 1'b0;
					end
				end else if (!pixel_done) begin
					pixel_gather_q  <= gather_next;
					byte_in_pixel_q <= byte_in_pixel_q + 2'd1;
				end else begin
					byte_in_pixel_q <= 2'd0;
					pixel_gather_q  <= 32'd0;
					if (image_done) begin
						pixels_decoded_q     <= 25'd0;
						expect_header_q      <= 1'b1;
						packet_is_run_q      <= 1'b0;
						packet_pixels_left_q <= 8'd0;
					end else begin
						pixels_decoded_q     <= decoded_next;
						packet_pixels_left_q <= left_next;
						if (left_next == 8'd0) begin
							expect_header_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			result_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = result_q;

endmodule

FILE: src/tga_rle_pixel_decoder.sv
// TGA run-length pixel decoder. Takes one coded byte per cycle while the result
// side does not stall; a result passes through the input register, then a
// combinational decode into the result register. A stall on the result side
// holds the result register and backs up into the input register, so the input
// takes a byte every cycle whenever the result side drains. Packet headers that
// fit the image and intermediate pixel bytes give no result. After an overflow
// the decoder drops all bytes until an item with restart set. Configuration is
// always accepted and is clamped on write.
module tga_rle_pixel_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
	input  logic        s_axis_tuser,   // [0] restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] pixel_value, [39:32] repeat_count,
	                                    // [63:40] first_index
	output logic        m_axis_tlast,   // image_done
	output logic        m_axis_tuser,   // [0] overflow_error
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [24:0] cfg_data
);
	import trpd_pkg::*;

	cfg_t    cfg;
	item_t   in_item;
	item_t   item;
	logic    item_valid;
	logic    advance;
	result_t result;

	assign in_item.stream_byte = s_axis_tdata;
	assign in_item.restart     = s_axis_tuser;

	trpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	trpd_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item       (item),
		.advance    (advance)
	);

	trpd_decode u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item       (item),
		.advance    (advance),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (result)
	);

	assign m_axis_tdata = {result.first_index, result.repeat_count, result.pixel_value};
	assign m_axis_tlast = result.image_done;
	assign m_axis_tuser = result.overflow_error;

endmodule

FILE: src/trpd_checker.sv
`include "tga_rle_pixel_decoder_assert.svh"

module trpd_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	logic       out_stall;
	logic       err_item;
	logic [7:0] rep_f;

	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign err_item  = m_axis_tvalid && m_axis_tuser;
	assign rep_f     = m_axis_tdata[39:32];

	// a stalled result holds
	`TRPD_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

	// overflow item carries no pixel and does not close the image
	`TRPD_ASSERT(a_err_item, err_item, m_axis_tdata[39:0] == 40'd0 && !m_axis_tlast)

	// a pixel item repeats one to 128 times
	`TRPD_ASSERT(a_repeat_range, m_axis_tvalid && !m_axis_tuser, rep_f != 8'd0 && rep_f <= 8'd128)

	// with the result side empty the input is never blocked
	`TRPD_ASSERT(a_in_open, !m_axis_tvalid, s_axis_tready)

endmodule

bind tga_rle_pixel_decoder trpd_port_checker u_trpd_checker (.*);

FILE: sim/trpd_checker.sv
module trpd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	input  logic        m_axis_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [24:0] cfg_data,
	output int          fails,
	output int          pending
);
	import trpd_pkg::*;

	logic [2:0]  bytes_reg;
	logic [24:0] size_reg;

	logic        hdr_wait;
	logic        in_run;
	logic [7:0]  pkt_left;
	logic [1:0]  byte_cnt;
	logic [31:0] gather;
	logic [24:0] done_cnt;
	logic        stuck;

	result_t pixel_q[$];

	function automatic logic [2:0] eff_bytes(input logic [2:0] v);
		if (v == 3'd0)
			return 3'd1;
		if (v > MAX_PIXEL_BYTES)
			return MAX_PIXEL_BYTES;
		return v;
	endfunction

	function automatic logic [24:0] eff_size(input logic [24:0] v);
		if (v == 25'd0)
			return 25'd1;
		if (v > MAX_IMAGE_PIXELS)
			return MAX_IMAGE_PIXELS;
		return v;
	endfunction

	task automatic clear_decode();
		hdr_wait = 1'b1;
		in_run   = 1'b0;
		pkt_left = '0;
		byte_cnt = '0;
		gather   = '0;
		done_cnt = '0;
		stuck    = 1'b0;
	endtask

	task automatic decode_byte(input item_t it);
		logic [2:0]  nb;
		logic [24:0] lim;
		logic [24:0] rem;
		logic [8:0]  cnt;
		logic [7:0]  rep;
		logic [24:0] first;
		logic [31:0] value;
		logic        run;
		logic        done;
		result_t     r;
		nb  = eff_bytes(bytes_reg);
		lim = eff_size(size_reg);
		if (it.restart) begin
			clear_decode();
			return;
		end
		if (stuck)
			return;
		if (hdr_wait) begin
			run = it.stream_byte >= RUN_FLAG;
			cnt = run ? {1'b0, it.stream_byte} - {1'b0, RUN_BIAS}
			          : {1'b0, it.stream_byte} + 9'd1;
			rem = (done_cnt < lim) ? lim - done_cnt : 25'd0;
			if ({16'd0, cnt} > rem) begin
				stuck = 1'b1;
				r = '0;
				r.first_index    = done_cnt[23:0];
				r.overflow_error = 1'b1;
				pixel_q.push_back(r);
				return;
			end
			in_run   = run;
			pkt_left = cnt[7:0];
			byte_cnt = '0;
			gather   = '0;
			hdr_wait = 1'b0;
			return;
		end
		gather   = gather | ({24'd0, it.stream_byte} << (byte_cnt * 8));
		byte_cnt = byte_cnt + 2'd1;
		if (byte_cnt != 2'd0 && {1'b0, byte_cnt} < nb)
			return;
		rep = in_run ? pkt_left : 8'd1;
		if (rep == 8'd0)
			rep = 8'd1;
		first    = done_cnt;
		value    = gather;
		done_cnt = done_cnt + {17'd0, rep};
		pkt_left = (pkt_left >= rep) ? pkt_left - rep : 8'd0;
		byte_cnt = '0;
		gather   = '0;
		if (pkt_left == 8'd0)
			hdr_wait = 1'b1;
		done = done_cnt >= lim;
		if (done) begin
			done_cnt = '0;
			hdr_wait = 1'b1;
			in_run   = 1'b0;
			pkt_left = '0;
		end
		r.pixel_value    = value;
		r.repeat_count   = rep;
		r.first_index    = first[23:0];
		r.image_done     = done;
		r.overflow_error = 1'b0;
		pixel_q.push_back(r);
	endtask

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fails++;
	endtask

	task automatic check_pixel();
		result_t want;
		if (pixel_q.size() == 0) begin
			report($sformatf("unexpected result data %h last %b user %b",
				m_axis_tdata, m_axis_tlast, m_axis_tuser));
			return;
		end
		want = pixel_q.pop_front();
		if (m_axis_tdata[31:0] !== want.pixel_value)
			report($sformatf("pixel_value got %h want %h",
				m_axis_tdata[31:0], want.pixel_value));
		if (m_axis_tdata[39:32] !== want.repeat_count)
			report($sformatf("repeat_count got %0d want %0d",
				m_axis_tdata[39:32], want.repeat_count));
		if (m_axis_tdata[63:40] !== want.first_index)
			report($sformatf("first_index got %0d want %0d",
				m_axis_tdata[63:40], want.first_index));
		if (m_axis_tlast !== want.image_done)
			report($sformatf("image_done got %b want %b",
				m_axis_tlast, want.image_done));
		if (m_axis_tuser !== want.overflow_error)
			report($sformatf("overflow_error got %b want %b",
				m_axis_tuser, want.overflow_error));
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t it;
		if (!arst_n) begin
			bytes_reg = 3'd3;
			size_reg  = 25'd1;
			fails     = 0;
			clear_decode();
			pixel_q.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_pixel();
			if (s_axis_tvalid && s_axis_tready) begin
				it.stream_byte = s_axis_tdata;
				it.restart     = s_axis_tuser;
				decode_byte(it);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_PIXEL_BYTES)
					bytes_reg = cfg_data[2:0];
				else
					size_reg = cfg_data;
			end
		end
		pending = pixel_q.size();
	end

endmodule

FILE: sim/tb_tga_rle_pixel_decoder.sv
module tb_tga_rle_pixel_decoder;
	import trpd_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 135;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_PIXEL_BYTES;
	logic [24:0] cfg_data = '0;

	int fails;
	int pending;
	int cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;

	// sender-side view of the current image
	int pb_eff = 3;
	int img_eff = 1;
	int img_left = 1;

	tga_rle_pixel_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	trpd_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fails(fails),
		.pending(pending)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic send_item(input logic [7:0] b, input logic rst);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= rst;
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic put(input logic [7:0] b);
		send_item(b, 1'b0);
	endtask

	task automatic restart_image(input logic [7:0] b);
		send_item(b, 1'b1);
		img_left = img_eff;
	endtask

	// stop sending, wait out every pending pixel and anything still in flight
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic set_reg(input logic idx, input logic [24:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_PIXEL_BYTES)
			pb_eff = (v[2:0] == 3'd0) ? 1 : (v[2:0] > 3'd4) ? 4 : int'(v[2:0]);
		else
			img_eff = (v == 25'd0) ? 1 : (v > MAX_IMAGE_PIXELS) ? 16777216 : int'(v);
	endtask

	task automatic send_packet();
		int lim;
		int cnt;
		bit run;
		lim = (img_left < 128) ? img_left : 128;
		run = $urandom_range(0, 99) < 55;
		if (run)
			cnt = $urandom_range(1, lim);
		else if ($urandom_range(0, 19) == 0)
			cnt = $urandom_range(1, (lim < 24) ? lim : 24);
		else
			cnt = $urandom_range(1, (lim < 5) ? lim : 5);
		put(run ? 8'(cnt + 127) : 8'(cnt - 1));
		repeat ((run ? 1 : cnt) * pb_eff)
			put(8'($urandom_range(0, 255)));
		img_left -= cnt;
		if (img_left == 0)
			img_left = img_eff;
	endtask

	task automatic random_config();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			set_reg(CFG_PIXEL_BYTES, 25'($urandom_range(0, 1) ? 0 : $urandom_range(5, 7)));
		else
			set_reg(CFG_PIXEL_BYTES, 25'($urandom_range(1, 4)));
		r = $urandom_range(0, 19);
		if (r < 14)
			set_reg(CFG_IMAGE_PIXELS, 25'($urandom_range(1, 24)));
		else if (r < 18)
			set_reg(CFG_IMAGE_PIXELS, 25'($urandom_range(100, 400)));
		else if (r == 18)
			set_reg(CFG_IMAGE_PIXELS, MAX_IMAGE_PIXELS);
		else
			set_reg(CFG_IMAGE_PIXELS, $urandom_range(0, 1) ? 25'h1FFFFFF : 25'd0);
		restart_image(8'($urandom_range(0, 255)));
	endtask

	task automatic random_phase(input int ipct, input int spct);
		int stop;
		int r;
		int cnt;
		idle_pct  = ipct;
		stall_pct = spct;
		random_config();
		stop = items_sent + PHASE_ITEMS;
		while (items_sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 76) begin
				send_packet();
			end else if (r < 83) begin
				// packet longer than what is left of the image, if that is under 128 pixels
				if (img_left < 128) begin
					cnt = $urandom_range(img_left + 1, 128);
					put($urandom_range(0, 1) ? 8'(cnt + 127) : 8'(cnt - 1));
					repeat ($urandom_range(0, 3))
						put(8'($urandom_range(0, 255)));
				end
				restart_image(8'($urandom_range(0, 255)));
			end else if (r < 88) begin
				restart_image(8'($urandom_range(0, 255)));
			end else if (r < 93) begin
				repeat ($urandom_range(1, 6))
					put(8'($urandom_range(0, 255)));
				restart_image(8'($urandom_range(0, 255)));
			end else if (r < 97) begin
				settle();
			end else begin
				random_config();
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset config: 3 bytes per pixel, one-pixel image
		put(8'h00); put(8'h00); put(8'hFF); put(8'hA5);
		put(8'h80); put(8'hFF); put(8'hFF); put(8'hFF);

		set_reg(CFG_PIXEL_BYTES, 25'd4);
		set_reg(CFG_IMAGE_PIXELS, 25'd5);
		// run of 128 into a 5-pixel image, then a dropped byte
		put(8'hFF); put(8'h12);
		restart_image(8'hFF);
		put(8'h83); put(8'h01); put(8'h02); put(8'h03); put(8'h04);
		put(8'h00); put(8'h80); put(8'h40); put(8'h20); put(8'h10);
		// restart in the middle of a pixel
		put(8'h01); put(8'hAA); put(8'hBB);
		restart_image(8'h00);

		// pixel width shrinks under a partly gathered pixel
		put(8'h00); put(8'h11); put(8'h22);
		set_reg(CFG_PIXEL_BYTES, 25'd1);
		put(8'h33);
		// image shrinks to no more than the pixels already decoded
		set_reg(CFG_IMAGE_PIXELS, 25'd1);
		put(8'h81);
		restart_image(8'h00);

		set_reg(CFG_PIXEL_BYTES, 25'd0);
		set_reg(CFG_IMAGE_PIXELS, 25'd0);
		restart_image(8'h00);
		put(8'h00); put(8'h7E);

		set_reg(CFG_PIXEL_BYTES, 25'd7);
		set_reg(CFG_IMAGE_PIXELS, 25'h1FFFFFF);
		restart_image(8'h00);
		put(8'hFF); put(8'hDE); put(8'hAD); put(8'hBE); put(8'hEF);
		restart_image(8'h55);

		random_phase(0, 0);
		random_phase(79, 0);
		random_phase(0, 79);
		random_phase(30, 30);

		settle();
		repeat (10) @(negedge clk);
		if (fails == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/trpd_pkg.sv
src/trpd_cfg.sv
src/trpd_in_stage.sv
src/trpd_decode.sv
src/tga_rle_pixel_decoder.sv
src/trpd_checker.sv
sim/trpd_checker.sv
sim/tb_tga_rle_pixel_decoder.sv
